[hw/rtl/scfd_pkg.sv]
// Package for the serial-line CAN frame deframer.
// Holds frame layout constants, opcodes, result kinds and register indexes.
// No dependencies.
package scfd_pkg;

    // frame layout
    localparam int unsigned HEADER_BYTES   = 11;
    localparam int unsigned MAX_DATA_BYTES = 8;

    localparam int unsigned POS_W   = 5;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned IDLE_W  = 16;
    localparam int unsigned MARK_W  = 8;
    localparam int unsigned TDATA_W = 104;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [IDLE_W-1:0] idle_t;

    // byte positions within a frame
    localparam pos_t POS_START    = 5'd0;
    localparam pos_t POS_LEN      = 5'd5;
    localparam pos_t POS_ID_FIRST = 5'd6;
    localparam pos_t POS_LAST_HDR = pos_t'(HEADER_BYTES - 1);

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_READY      = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT    = 2'd1;
    localparam logic [1:0] KIND_BAD_START  = 2'd2;
    localparam logic [1:0] KIND_BAD_LENGTH = 2'd3;

    // configuration register indexes
    localparam logic CFG_START_MARKER  = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [MARK_W-1:0] START_MARKER_RST  = 8'hAA;
    localparam idle_t             TIMEOUT_TICKS_RST = 16'd1000;

endpackage

[hw/rtl/serial_to_can_frame_deframer_unit.sv]
// Serial-line CAN frame deframer, top level.
// Depends on scfd_pkg.
//
//  Channel   Direction  Carries
//  s_*       in         one serial byte or one timer tick per transaction
//  m_*       out        frame ready or drop notice
//  cfg_*     in         register writes (start marker, timeout ticks)
//
// One item per cycle while s_tready is high: each byte or tick updates the frame state,
// and its result is loaded into the output register at the accepting edge.
// The output register is the only holding stage; s_tready drops only while
// a result waits and m_tready is low. cfg_ready is always high.
// Reset clears the frame control state (not id/payload) and loads the register defaults.
module serial_to_can_frame_deframer_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] byte_value
    input  logic                        s_tuser,   // [0] opcode
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [scfd_pkg::TDATA_W-1:0] m_tdata,  // [31:0] frame_id,
                                                   // [35:32] data_length,
                                                   // [99:36] payload, [103:100] zero
    output logic [1:0]                  m_tuser,   // [1:0] result_kind
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [15:0]                 cfg_data
);
    import scfd_pkg::*;

    // configuration
    logic [MARK_W-1:0] start_marker_reg;
    idle_t             timeout_ticks_reg;

    // frame state
    pos_t               pos_reg, pos_next;
    logic               start_ok_reg, start_ok_next;
    logic               len_bad_reg, len_bad_next;
    len_t               len_reg, len_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DATA_W-1:0]  payload_reg, payload_next;
    idle_t              idle_reg, idle_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    len_t               out_len_reg, out_len_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;

    logic               in_take;
    logic               emit;
    idle_t              idle_inc;
    idle_t              limit;
    pos_t               data_idx;
    logic [1:0]         id_lane;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + idle_t'(1);
    assign limit    = (timeout_ticks_reg == '0) ? idle_t'(1) : timeout_ticks_reg;
    assign data_idx = pos_reg - POS_LAST_HDR;
    // identifier byte lane, wraps within two bits
    assign id_lane  = pos_reg[1:0] - POS_ID_FIRST[1:0];

    always_comb
    begin
        pos_next      = pos_reg;
        start_ok_next = start_ok_reg;
        len_bad_next  = len_bad_reg;
        len_next      = len_reg;
        id_next       = id_reg;
        payload_next  = payload_reg;
        idle_next     = idle_reg;
        emit          = 1'b0;
        kind_next     = KIND_READY;
        out_id_next   = '0;
        out_len_next  = '0;
        out_data_next = '0;

        if (in_take)
        begin
            if (s_tuser == OP_TICK)
            begin
                if (pos_reg != POS_START)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= limit)
                    begin
                        // drop the partial frame
                        idle_next = '0;
                        pos_next  = POS_START;
                        emit      = 1'b1;
                        kind_next = KIND_TIMEOUT;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                if (pos_reg == POS_START)
                begin
                    start_ok_next = (s_tdata == start_marker_reg);
                    pos_next      = pos_reg + pos_t'(1);
                end
                else if (pos_reg < POS_LEN)
                begin
                    pos_next = pos_reg + pos_t'(1);
                end
                else if (pos_reg == POS_LEN)
                begin
                    len_bad_next = (s_tdata > 8'(MAX_DATA_BYTES));
                    len_next     = s_tdata[LEN_W-1:0];
                    pos_next     = pos_reg + pos_t'(1);
                end
                else if (pos_reg < POS_LAST_HDR)
                begin
                    // identifier, least significant byte first
                    id_next[8*id_lane +: 8] = s_tdata;
                    pos_next = pos_reg + pos_t'(1);
                end
                else if (pos_reg == POS_LAST_HDR)
                begin
                    pos_next = POS_START;
                    if (!start_ok_reg)
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_BAD_START;
                    end
                    else if (len_bad_reg)
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_BAD_LENGTH;
                    end
                    else if (len_reg == '0)
                    begin
                        // this byte is the end byte
                        emit        = 1'b1;
                        kind_next   = KIND_READY;
                        out_id_next = id_reg;
                    end
                    else
                    begin
                        payload_next = {{(DATA_W-8){1'b0}}, s_tdata};
                        pos_next     = pos_reg + pos_t'(1);
                    end
                end
                else
                begin
                    if (data_idx < pos_t'(len_reg))
                    begin
                        payload_next[8*data_idx[2:0] +: 8] = s_tdata;
                        pos_next = pos_reg + pos_t'(1);
                    end
                    else
                    begin
                        // end byte closes the frame
                        pos_next      = POS_START;
                        emit          = 1'b1;
                        kind_next     = KIND_READY;
                        out_id_next   = id_reg;
                        out_len_next  = len_reg;
                        out_data_next = payload_reg;
                    end
                end
            end
        end

        if (emit)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= START_MARKER_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_MARKER:  start_marker_reg  <= cfg_data[MARK_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:           start_marker_reg  <= start_marker_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_START;
            start_ok_reg <= 1'b0;
            len_bad_reg  <= 1'b0;
            len_reg      <= '0;
            idle_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            start_ok_reg <= start_ok_next;
            len_bad_reg  <= len_bad_next;
            len_reg      <= len_next;
            idle_reg     <= idle_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        payload_reg <= payload_next;
        if (emit)
        begin
            kind_reg     <= kind_next;
            out_id_reg   <= out_id_next;
            out_len_reg  <= out_len_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {4'b0000, out_data_reg, out_len_reg, out_id_reg};

endmodule

[hw/rtl/scfd_checker.sv]
// Port-level checker for the serial-line CAN frame deframer.
// Depends on scfd_pkg; bound to serial_to_can_frame_deframer_unit below.
module scfd_port_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [scfd_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import scfd_pkg::*;

    // drop notices carry no frame contents
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_READY |-> m_tdata == '0)
        else $error("drop transaction carries non-zero data");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_READY |-> m_tdata[35:32] <= 4'(MAX_DATA_BYTES))
        else $error("ready frame length above maximum");

    // a tick can only ever produce a timeout notice
    a_tick_kind: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_TICK && !(m_tvalid && !m_tready)
        |=> !m_tvalid || m_tuser == KIND_TIMEOUT)
        else $error("tick produced a non-timeout result");

    // a stalled result blocks the input
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind serial_to_can_frame_deframer_unit scfd_port_checker u_scfd_port_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
